FILE: design/hbra_pkg.sv
// shared types, constants and codes of the heat based residency admission block
package hbra_pkg;
  localparam int NUM_ITEMS    = 1024;
  localparam int MAX_RESIDENT = 16;
  localparam int ID_W         = 10;
  localparam int BYTES_W      = 40;
  localparam int HEAT_W       = 32;
  localparam int SEQ_W        = 48;
  localparam int STATUS_W     = 4;
  localparam int HADDR_W      = $clog2(NUM_ITEMS);
  localparam int SLOT_W       = (MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1;
  localparam int CNT_W        = $clog2(MAX_RESIDENT + 1);
  localparam int CLR_W        = HADDR_W + 1;
  localparam int SUM_W        = BYTES_W + CNT_W;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INV  = 1'd1;

  localparam logic [BYTES_W-1:0] CAPACITY_RST = 40'd1073741824;
  localparam logic [HEAT_W-1:0]  MIN_INV_RST  = 32'd1;

  localparam logic [STATUS_W-1:0] ST_HIT     = 4'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 4'd1;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 4'd2;
  localparam logic [STATUS_W-1:0] ST_SIZE    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_COLD    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_LARGE   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_HOTTER  = 4'd6;
  localparam logic [STATUS_W-1:0] ST_INVALID = 4'd7;

  localparam logic KIND_EVICT    = 1'b0;
  localparam logic KIND_DECISION = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] bytes;
    logic [HEAT_W-1:0]  heat;
    logic [SEQ_W-1:0]   last_use;
  } slot_t;

  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     evicted_id;
    logic [STATUS_W-1:0] status;
    logic                admitted;
    logic                hit_flag;
    logic [HEAT_W-1:0]   heat;
    logic [BYTES_W-1:0]  total_bytes;
    logic                is_last;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HRD, S_LK_RD, S_LK_EV, S_VIC_CHK, S_VIC_RD, S_VIC_EV,
    S_VIC_DEC, S_EM_RD, S_EM_OUT, S_INS, S_FIN
  } state_t;

  function automatic logic colder(slot_t a, slot_t b);
    if (a.heat != b.heat) return a.heat < b.heat;
    if (a.last_use != b.last_use) return a.last_use < b.last_use;
    return a.id < b.id;
  endfunction
endpackage

FILE: design/hbra_req_if.sv
// request channel interface
interface hbra_req_if import hbra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    item_id;
  logic [BYTES_W-1:0] item_bytes;
  modport source (output valid, item_id, item_bytes, input ready);
  modport sink (input valid, item_id, item_bytes, output ready);
endinterface

FILE: design/hbra_res_if.sv
// result channel interface
interface hbra_res_if import hbra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ID_W-1:0]     evicted_id;
  logic [STATUS_W-1:0] status;
  logic                admitted;
  logic                hit_flag;
  logic [HEAT_W-1:0]   heat;
  logic [BYTES_W-1:0]  total_bytes;
  logic                is_last;
  modport source (output valid, kind, evicted_id, status, admitted, hit_flag, heat,
                  total_bytes, is_last, input ready);
  modport sink (input valid, kind, evicted_id, status, admitted, hit_flag, heat,
                total_bytes, is_last, output ready);
endinterface

FILE: design/hbra_ram.sv
// generic single write port ram with registered read
module hbra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/heat_based_residency_admission.sv
// top level of the heat based residency admission block
//
//  channel  dir  handshake      payload
//  in_req   in   valid/ready    item_id, item_bytes
//  out_res  out  valid/ready    kind, evicted_id, status, admitted, hit_flag,
//                               heat, total_bytes, is_last
//  cfg      in   cfg_we         cfg_index, cfg_wdata
//
// after reset all heat memory entries are cleared, one entry a cycle, and no requests are taken meanwhile
// a request reads its heat, then scans the slot memory for a hit; to make room it scans the slot
// memory once per victim for the coldest slot, then reports each victim, inserts and finishes
// one request at a time; the result register lets a new request start while it waits
// a stalled result channel holds the sequencer at its next transfer
module heat_based_residency_admission
  import hbra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  hbra_req_if.sink             in_req,
  hbra_res_if.source           out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0]   cfg_wdata
);
  state_t state_r, state_nxt;

  logic [BYTES_W-1:0] cap_r;
  logic [HEAT_W-1:0]  min_inv_r;
  logic [CLR_W-1:0]   clr_r, clr_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [HEAT_W-1:0]  heat_r, heat_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [BYTES_W-1:0] total_r, total_nxt;
  logic [MAX_RESIDENT-1:0] valid_r, valid_nxt;
  logic [MAX_RESIDENT-1:0] picked_r, picked_nxt;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]   nvict_r, nvict_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [SLOT_W-1:0]  order_r [MAX_RESIDENT];
  logic [SLOT_W-1:0]  order_nxt [MAX_RESIDENT];
  logic [SUM_W-1:0]   reclaim_r, reclaim_nxt;
  slot_t              best_r, best_nxt;
  logic [SLOT_W-1:0]  best_idx_r, best_idx_nxt;
  logic               found_r, found_nxt;
  res_t               res_r, res_nxt;
  res_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               heat_we;
  logic [HADDR_W-1:0] heat_waddr, heat_raddr;
  logic [HEAT_W-1:0]  heat_wdata, heat_rdata;
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
  slot_t              slot_wdata, slot_rdata;

  logic               in_fire, out_free, last_idx, need_more, slots_full;
  logic [HEAT_W-1:0]  heat_inc;
  logic [BYTES_W-1:0] avail;
  logic [SLOT_W-1:0]  free_idx;

  assign in_fire    = in_req.valid && in_req.ready;
  assign out_free   = !out_valid_r || out_res.ready;
  assign last_idx   = idx_r == SLOT_W'(MAX_RESIDENT - 1);
  assign slots_full = $countones(valid_r) == MAX_RESIDENT;
  assign avail      = (cap_r > total_r) ? cap_r - total_r : '0;
  assign need_more  = (SUM_W'(avail) + reclaim_r < SUM_W'(bytes_r))
                      || (slots_full && nvict_r == '0);
  assign heat_inc   = (heat_rdata == '1) ? heat_rdata : heat_rdata + 1'b1;

  always_comb begin
    free_idx = '0;
    for (int i = MAX_RESIDENT - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = SLOT_W'(i);
    end
  end

  hbra_ram #(.WIDTH(HEAT_W), .DEPTH(NUM_ITEMS)) u_heat_ram (
    .clk, .we(heat_we), .waddr(heat_waddr), .wdata(heat_wdata),
    .raddr(heat_raddr), .rdata(heat_rdata)
  );

  hbra_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_RESIDENT)) u_slot_ram (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (clr_r == CLR_W'(NUM_ITEMS - 1)) state_nxt = S_IDLE;
      S_IDLE:    if (in_fire) state_nxt = S_HRD;
      S_HRD:     state_nxt = (bytes_r == '0) ? S_FIN : S_LK_RD;
      S_LK_RD:   state_nxt = S_LK_EV;
      S_LK_EV: begin
        if (valid_r[idx_r] && slot_rdata.id == id_r) state_nxt = S_FIN;
        else if (last_idx) begin
          if (heat_r < min_inv_r || bytes_r > cap_r) state_nxt = S_FIN;
          else state_nxt = S_VIC_CHK;
        end else state_nxt = S_LK_RD;
      end
      S_VIC_CHK: begin
        if (need_more) state_nxt = S_VIC_RD;
        else if (nvict_r != '0) state_nxt = S_EM_RD;
        else state_nxt = S_INS;
      end
      S_VIC_RD:  state_nxt = S_VIC_EV;
      S_VIC_EV:  state_nxt = last_idx ? S_VIC_DEC : S_VIC_RD;
      S_VIC_DEC: begin
        if (!found_r || best_r.heat >= heat_r) state_nxt = S_FIN;
        else state_nxt = S_VIC_CHK;
      end
      S_EM_RD:   state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        if (out_free) state_nxt = (k_r + 1'b1 == nvict_r) ? S_INS : S_EM_RD;
      end
      S_INS:     state_nxt = S_FIN;
      S_FIN:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_nxt       = clr_r;
    id_nxt        = id_r;
    bytes_nxt     = bytes_r;
    heat_nxt      = heat_r;
    seq_nxt       = seq_r;
    total_nxt     = total_r;
    valid_nxt     = valid_r;
    picked_nxt    = picked_r;
    idx_nxt       = idx_r;
    nvict_nxt     = nvict_r;
    k_nxt         = k_r;
    order_nxt     = order_r;
    reclaim_nxt   = reclaim_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    heat_we       = 1'b0;
    heat_waddr    = id_r[HADDR_W-1:0];
    heat_wdata    = heat_inc;
    heat_raddr    = in_req.item_id[HADDR_W-1:0];
    slot_we       = 1'b0;
    slot_waddr    = idx_r;
    slot_wdata    = '{id: id_r, bytes: bytes_r, heat: heat_r, last_use: seq_r};
    slot_raddr    = idx_r;

    res_nxt.kind       = KIND_DECISION;
    res_nxt.evicted_id = '0;
    res_nxt.is_last    = 1'b1;

    case (state_r)
      S_CLEAR: begin
        heat_we    = 1'b1;
        heat_waddr = clr_r[HADDR_W-1:0];
        heat_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
      end
      S_IDLE: begin
        id_nxt    = in_req.item_id;
        bytes_nxt = in_req.item_bytes;
      end
      S_HRD: begin
        idx_nxt = '0;
        if (bytes_r == '0) begin
          res_nxt.status   = ST_INVALID;
          res_nxt.admitted = 1'b0;
          res_nxt.hit_flag = 1'b0;
          res_nxt.heat     = heat_rdata;
        end else begin
          heat_we  = 1'b1;
          heat_nxt = heat_inc;
          seq_nxt  = seq_r + 1'b1;
        end
      end
      S_LK_EV: begin
        idx_nxt          = idx_r + 1'b1;
        res_nxt.heat     = heat_r;
        res_nxt.admitted = 1'b0;
        res_nxt.hit_flag = 1'b0;
        if (valid_r[idx_r] && slot_rdata.id == id_r) begin
          if (slot_rdata.bytes != bytes_r) begin
            res_nxt.status = ST_SIZE;
          end else begin
            slot_we          = 1'b1;
            res_nxt.status   = ST_HIT;
            res_nxt.admitted = 1'b1;
            res_nxt.hit_flag = 1'b1;
          end
        end else if (heat_r < min_inv_r) begin
          res_nxt.status = ST_COLD;
        end else if (bytes_r > cap_r) begin
          res_nxt.status = ST_LARGE;
        end
        nvict_nxt   = '0;
        picked_nxt  = '0;
        reclaim_nxt = '0;
      end
      S_VIC_CHK: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        k_nxt     = '0;
      end
      S_VIC_EV: begin
        idx_nxt = idx_r + 1'b1;
        if (valid_r[idx_r] && !picked_r[idx_r]
            && (!found_r || colder(slot_rdata, best_r))) begin
          found_nxt    = 1'b1;
          best_nxt     = slot_rdata;
          best_idx_nxt = idx_r;
        end
      end
      S_VIC_DEC: begin
        if (!found_r || best_r.heat >= heat_r) begin
          res_nxt.status   = ST_HOTTER;
          res_nxt.admitted = 1'b0;
          res_nxt.hit_flag = 1'b0;
          res_nxt.heat     = heat_r;
        end else begin
          picked_nxt[best_idx_r]           = 1'b1;
          order_nxt[nvict_r[SLOT_W-1:0]]   = best_idx_r;
          nvict_nxt                        = nvict_r + 1'b1;
          reclaim_nxt = reclaim_r + SUM_W'(best_r.bytes);
        end
      end
      S_EM_RD: begin
        slot_raddr = order_r[k_r[SLOT_W-1:0]];
      end
      S_EM_OUT: begin
        slot_raddr = order_r[k_r[SLOT_W-1:0]];
        if (out_free) begin
          total_nxt                       = total_r - slot_rdata.bytes;
          valid_nxt[order_r[k_r[SLOT_W-1:0]]] = 1'b0;
          k_nxt                           = k_r + 1'b1;
          out_valid_nxt                   = 1'b1;
          out_nxt = '{kind: KIND_EVICT, evicted_id: slot_rdata.id, status: ST_EVICTED,
                      admitted: 1'b1, hit_flag: 1'b0, heat: heat_r,
                      total_bytes: total_r - slot_rdata.bytes, is_last: 1'b0};
        end
      end
      S_INS: begin
        slot_we            = 1'b1;
        slot_waddr         = free_idx;
        valid_nxt[free_idx] = 1'b1;
        total_nxt          = total_r + bytes_r;
        res_nxt.status     = (nvict_r != '0) ? ST_EVICTED : ST_LOADED;
        res_nxt.admitted   = 1'b1;
        res_nxt.hit_flag   = 1'b0;
        res_nxt.heat       = heat_r;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt             = res_r;
          out_nxt.total_bytes = total_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cap_r       <= CAPACITY_RST;
      min_inv_r   <= MIN_INV_RST;
      seq_r       <= '0;
      total_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      seq_r       <= seq_nxt;
      total_r     <= total_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_CAPACITY) cap_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_MIN_INV) min_inv_r <= cfg_wdata[HEAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    bytes_r    <= bytes_nxt;
    heat_r     <= heat_nxt;
    picked_r   <= picked_nxt;
    idx_r      <= idx_nxt;
    nvict_r    <= nvict_nxt;
    k_r        <= k_nxt;
    order_r    <= order_nxt;
    reclaim_r  <= reclaim_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    found_r    <= found_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign in_req.ready        = state_r == S_IDLE;
  assign out_res.valid       = out_valid_r;
  assign out_res.kind        = out_r.kind;
  assign out_res.evicted_id  = out_r.evicted_id;
  assign out_res.status      = out_r.status;
  assign out_res.admitted    = out_r.admitted;
  assign out_res.hit_flag    = out_r.hit_flag;
  assign out_res.heat        = out_r.heat;
  assign out_res.total_bytes = out_r.total_bytes;
  assign out_res.is_last     = out_r.is_last;

  a_evict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.kind == KIND_EVICT |-> out_res.status == ST_EVICTED
      && !out_res.is_last && out_res.admitted)
    else $error("eviction report fields wrong");

  a_last_is_decision: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.is_last |-> out_res.kind == KIND_DECISION)
    else $error("final result not a decision");

  a_heat_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_HRD)
    else $error("accepted request not looked up");

  a_victims_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EM_OUT |-> k_r < nvict_r && nvict_r <= CNT_W'(MAX_RESIDENT))
    else $error("eviction count out of range");
endmodule
